/* rtl/jlx_pkg.sv */
// shared types, codes and character classes of the json lexer
package jlx_pkg;

  typedef logic [3:0] mode_t;
  typedef logic [4:0] kind_t;
  typedef logic [7:0] char_t;

  // lexer modes
  localparam mode_t M_IDLE   = 4'd0;
  localparam mode_t M_SLASH  = 4'd1;
  localparam mode_t M_LINE   = 4'd2;
  localparam mode_t M_BLOCK  = 4'd3;
  localparam mode_t M_BSTAR  = 4'd4;
  localparam mode_t M_MINUS  = 4'd5;
  localparam mode_t M_STRING = 4'd6;
  localparam mode_t M_ESC    = 4'd7;
  localparam mode_t M_IDENT  = 4'd8;
  localparam mode_t M_NUMBER = 4'd9;

  // token kinds
  localparam kind_t K_END       = 5'd0;
  localparam kind_t K_DOT       = 5'd1;
  localparam kind_t K_COMMA     = 5'd2;
  localparam kind_t K_COLON     = 5'd3;
  localparam kind_t K_SEMICOLON = 5'd4;
  localparam kind_t K_STAR      = 5'd5;
  localparam kind_t K_EQUALS    = 5'd6;
  localparam kind_t K_LPAREN    = 5'd7;
  localparam kind_t K_RPAREN    = 5'd8;
  localparam kind_t K_LBRACKET  = 5'd9;
  localparam kind_t K_RBRACKET  = 5'd10;
  localparam kind_t K_LBRACE    = 5'd11;
  localparam kind_t K_RBRACE    = 5'd12;
  localparam kind_t K_STRING    = 5'd13;
  localparam kind_t K_IDENT     = 5'd14;
  localparam kind_t K_INT       = 5'd15;
  localparam kind_t K_FLOAT     = 5'd16;
  localparam kind_t K_UNKNOWN   = 5'd17;

  // characters
  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_TAB    = 8'h09;
  localparam char_t CH_LF     = 8'h0A;
  localparam char_t CH_VT     = 8'h0B;
  localparam char_t CH_FF     = 8'h0C;
  localparam char_t CH_CR     = 8'h0D;
  localparam char_t CH_SPACE  = 8'h20;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_COLON  = 8'h3A;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_EQUALS = 8'h3D;
  localparam char_t CH_LBRACK = 8'h5B;
  localparam char_t CH_BSLASH = 8'h5C;
  localparam char_t CH_RBRACK = 8'h5D;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;

  // result queue depth
  localparam int QDEPTH = 4;

  function automatic logic is_digit(input char_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input char_t b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_skip(input char_t b);
    return (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) || (b == CH_SPACE) ||
           (b == CH_CR) || (b == CH_LF);
  endfunction

  // single-character token kind, K_END when the byte is no punctuation
  function automatic kind_t punct_kind(input char_t b);
    kind_t k;
    k = K_END;
    case (b)
      CH_DOT:    k = K_DOT;
      CH_COMMA:  k = K_COMMA;
      CH_COLON:  k = K_COLON;
      CH_SEMI:   k = K_SEMICOLON;
      CH_STAR:   k = K_STAR;
      CH_EQUALS: k = K_EQUALS;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACK: k = K_LBRACKET;
      CH_RBRACK: k = K_RBRACKET;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      default:   k = K_END;
    endcase
    return k;
  endfunction

endpackage

/* rtl/json_lexer_byte_stream.sv */
// top level of the streaming json lexer with comment skipping
// json_lexer_byte_stream: cuts a byte stream into json-style tokens
//
// input channel: one text byte per transfer (in_valid / in_ready); a zero
//   byte ends the stream, emits the end token and returns the lexer to reset
// output channel: one token per transfer (out_valid / out_ready) with kind,
//   start offset, length and last_of_run, which marks the final token that
//   a byte caused (a byte causes zero, one or two tokens)
// path: a byte is captured in an input register; once the queue has room,
//   the lexer logic updates the mode and open-token registers and writes
//   its tokens into a four-entry result queue, whose head drives out_valid
//   and the token fields
// throughput: one byte per cycle while the receiver keeps up; the output
//   drains one token per cycle, so bytes that cause two tokens (a closed
//   identifier, number or lone slash/minus followed by a one-byte token,
//   or a string cut by the zero byte) cost it an extra transfer each, and
//   the queue must have room for two tokens before a byte is processed
// reset (rst_n low, synchronous): lexer idle, position zero, queue empty
// stall: with out_ready low, tokens wait in the queue; once it cannot take
//   two more, the held byte waits and in_ready drops
module json_lexer_byte_stream #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             out_token_kind,
  output logic [OFFSET_BITS-1:0] out_start_offset,
  output logic [OFFSET_BITS-1:0] out_token_length,
  output logic                   out_last_of_run
);
  import jlx_pkg::*;

  localparam int PTR_BITS = $clog2(QDEPTH);
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  // input register
  logic  byte_vld_r;
  char_t byte_r;

  // lexer state
  mode_t                  mode_r, mode_nxt;
  logic                   seen_dot_r, seen_dot_nxt;
  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [OFFSET_BITS-1:0] open_start_r, open_start_nxt;
  logic [OFFSET_BITS-1:0] open_len_r, open_len_nxt;

  // tokens from the lexer logic
  logic [1:0]             res_cnt;
  kind_t                  res_kind [2];
  logic [OFFSET_BITS-1:0] res_start [2];
  logic [OFFSET_BITS-1:0] res_len [2];

  // result queue
  kind_t                  q_kind_r  [QDEPTH];
  logic [OFFSET_BITS-1:0] q_start_r [QDEPTH];
  logic [OFFSET_BITS-1:0] q_len_r   [QDEPTH];
  logic                   q_last_r  [QDEPTH];
  logic [PTR_BITS-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]    q_cnt_r, q_cnt_nxt;
  logic [PTR_BITS-1:0]    wr_ptr_p1;

  logic pop;
  logic room;
  logic proc;
  logic [1:0] push_cnt;

  jlx_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .mode           (mode_r),
    .seen_dot       (seen_dot_r),
    .byte_pos       (byte_pos_r),
    .open_start     (open_start_r),
    .open_len       (open_len_r),
    .text_byte      (byte_r),
    .mode_nxt       (mode_nxt),
    .seen_dot_nxt   (seen_dot_nxt),
    .byte_pos_nxt   (byte_pos_nxt),
    .open_start_nxt (open_start_nxt),
    .open_len_nxt   (open_len_nxt),
    .res_cnt        (res_cnt),
    .res_kind       (res_kind),
    .res_start      (res_start),
    .res_len        (res_len)
  );

  // output side pops the queue head
  assign out_valid        = (q_cnt_r != '0);
  assign pop              = out_valid && out_ready;
  assign out_token_kind   = q_kind_r[rd_ptr_r];
  assign out_start_offset = q_start_r[rd_ptr_r];
  assign out_token_length = q_len_r[rd_ptr_r];
  assign out_last_of_run  = q_last_r[rd_ptr_r];

  // a held byte is processed once the queue can take two tokens
  assign room     = ({1'b0, q_cnt_r} + (CNT_BITS + 1)'(2)) <=
                    ((CNT_BITS + 1)'(QDEPTH) + {{CNT_BITS{1'b0}}, pop});
  assign proc     = byte_vld_r && room;
  assign in_ready = !byte_vld_r || proc;
  assign push_cnt = proc ? res_cnt : 2'd0;

  assign wr_ptr_p1 = wr_ptr_r + PTR_BITS'(1);
  assign q_cnt_nxt = q_cnt_r + CNT_BITS'(push_cnt) - CNT_BITS'(pop);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      mode_r       <= M_IDLE;
      seen_dot_r   <= 1'b0;
      byte_pos_r   <= '0;
      open_start_r <= '0;
      open_len_r   <= '0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      q_cnt_r      <= '0;
    end else begin
      if (in_ready) begin
        byte_vld_r <= in_valid;
      end
      if (proc) begin
        mode_r       <= mode_nxt;
        seen_dot_r   <= seen_dot_nxt;
        byte_pos_r   <= byte_pos_nxt;
        open_start_r <= open_start_nxt;
        open_len_r   <= open_len_nxt;
      end
      wr_ptr_r <= wr_ptr_r + PTR_BITS'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_text_byte;
    end
    if (push_cnt != 2'd0) begin
      q_kind_r[wr_ptr_r]  <= res_kind[0];
      q_start_r[wr_ptr_r] <= res_start[0];
      q_len_r[wr_ptr_r]   <= res_len[0];
      q_last_r[wr_ptr_r]  <= (push_cnt == 2'd1);
    end
    if (push_cnt == 2'd2) begin
      q_kind_r[wr_ptr_p1]  <= res_kind[1];
      q_start_r[wr_ptr_p1] <= res_start[1];
      q_len_r[wr_ptr_p1]   <= res_len[1];
      q_last_r[wr_ptr_p1]  <= 1'b1;
    end
  end

endmodule

/* rtl/jlx_core.sv */
// next-state and token logic of the lexer for one byte
module jlx_core #(
  parameter int OFFSET_BITS = 16
) (
  input  jlx_pkg::mode_t          mode,
  input  logic                    seen_dot,
  input  logic [OFFSET_BITS-1:0]  byte_pos,
  input  logic [OFFSET_BITS-1:0]  open_start,
  input  logic [OFFSET_BITS-1:0]  open_len,
  input  jlx_pkg::char_t          text_byte,
  output jlx_pkg::mode_t          mode_nxt,
  output logic                    seen_dot_nxt,
  output logic [OFFSET_BITS-1:0]  byte_pos_nxt,
  output logic [OFFSET_BITS-1:0]  open_start_nxt,
  output logic [OFFSET_BITS-1:0]  open_len_nxt,
  output logic [1:0]              res_cnt,
  output jlx_pkg::kind_t          res_kind [2],
  output logic [OFFSET_BITS-1:0]  res_start [2],
  output logic [OFFSET_BITS-1:0]  res_len [2]
);
  import jlx_pkg::*;

  localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (&v) ? v : v + ONE;
  endfunction

  logic                   fresh;
  logic                   close_vld;
  kind_t                  close_kind;
  logic [OFFSET_BITS-1:0] close_len;
  logic                   own_vld;
  kind_t                  own_kind;
  logic [OFFSET_BITS-1:0] own_start;
  logic                   is_end;
  logic                   b_nul;

  assign b_nul = (text_byte == CH_NUL);

  always_comb begin
    mode_nxt       = mode;
    seen_dot_nxt   = seen_dot;
    open_start_nxt = open_start;
    open_len_nxt   = open_len;
    fresh          = 1'b0;
    close_vld      = 1'b0;
    close_kind     = K_UNKNOWN;
    close_len      = open_len;
    own_vld        = 1'b0;
    own_kind       = K_UNKNOWN;
    own_start      = byte_pos;
    is_end         = 1'b0;

    // continue or close the open token
    unique case (mode)
      M_SLASH: begin
        if (text_byte == CH_SLASH) begin
          mode_nxt = M_LINE;
        end else if (text_byte == CH_STAR) begin
          mode_nxt = M_BLOCK;
        end else begin
          close_vld = 1'b1;
          close_len = ONE;
          fresh     = 1'b1;
        end
      end
      M_LINE: begin
        if (b_nul) begin
          fresh = 1'b1;
        end else if ((text_byte == CH_CR) || (text_byte == CH_LF)) begin
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (b_nul) begin
          fresh = 1'b1;
        end else if (text_byte == CH_STAR) begin
          mode_nxt = M_BSTAR;
        end
      end
      M_BSTAR: begin
        if (b_nul) begin
          fresh = 1'b1;
        end else if (text_byte == CH_SLASH) begin
          mode_nxt = M_IDLE;
        end else if (text_byte != CH_STAR) begin
          mode_nxt = M_BLOCK;
        end
      end
      M_MINUS: begin
        if (is_digit(text_byte)) begin
          mode_nxt     = M_NUMBER;
          seen_dot_nxt = 1'b0;
          open_len_nxt = OFFSET_BITS'(2);
        end else begin
          close_vld = 1'b1;
          close_len = ONE;
          fresh     = 1'b1;
        end
      end
      M_STRING: begin
        if (b_nul) begin
          close_vld  = 1'b1;
          close_kind = K_STRING;
          fresh      = 1'b1;
        end else if (text_byte == CH_QUOTE) begin
          close_vld  = 1'b1;
          close_kind = K_STRING;
          mode_nxt   = M_IDLE;
        end else begin
          open_len_nxt = sat_inc(open_len);
          if (text_byte == CH_BSLASH) begin
            mode_nxt = M_ESC;
          end
        end
      end
      M_ESC: begin
        if (b_nul) begin
          close_vld  = 1'b1;
          close_kind = K_STRING;
          fresh      = 1'b1;
        end else begin
          open_len_nxt = sat_inc(open_len);
          mode_nxt     = M_STRING;
        end
      end
      M_IDENT: begin
        if (is_alpha(text_byte) || is_digit(text_byte)) begin
          open_len_nxt = sat_inc(open_len);
        end else begin
          close_vld  = 1'b1;
          close_kind = K_IDENT;
          fresh      = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(text_byte) || (text_byte == CH_DOT)) begin
          open_len_nxt = sat_inc(open_len);
          if (text_byte == CH_DOT) begin
            seen_dot_nxt = 1'b1;
          end
        end else begin
          close_vld  = 1'b1;
          close_kind = seen_dot ? K_FLOAT : K_INT;
          fresh      = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // the byte on its own, between tokens
    if (fresh) begin
      mode_nxt = M_IDLE;
      if (b_nul) begin
        own_vld  = 1'b1;
        own_kind = K_END;
        is_end   = 1'b1;
      end else if (is_skip(text_byte)) begin
        mode_nxt = M_IDLE;
      end else if (text_byte == CH_SLASH) begin
        mode_nxt       = M_SLASH;
        open_start_nxt = byte_pos;
        open_len_nxt   = ONE;
      end else if (text_byte == CH_MINUS) begin
        mode_nxt       = M_MINUS;
        open_start_nxt = byte_pos;
        open_len_nxt   = ONE;
      end else if (text_byte == CH_QUOTE) begin
        mode_nxt       = M_STRING;
        open_start_nxt = sat_inc(byte_pos);
        open_len_nxt   = '0;
      end else if (is_alpha(text_byte)) begin
        mode_nxt       = M_IDENT;
        open_start_nxt = byte_pos;
        open_len_nxt   = ONE;
      end else if (is_digit(text_byte) || (text_byte == CH_PLUS)) begin
        mode_nxt       = M_NUMBER;
        open_start_nxt = byte_pos;
        open_len_nxt   = ONE;
        seen_dot_nxt   = 1'b0;
      end else if (punct_kind(text_byte) != K_END) begin
        own_vld  = 1'b1;
        own_kind = punct_kind(text_byte);
      end else begin
        own_vld  = 1'b1;
        own_kind = K_UNKNOWN;
      end
    end

    // zero byte brings the whole state back to reset
    if (is_end) begin
      mode_nxt       = M_IDLE;
      seen_dot_nxt   = 1'b0;
      open_start_nxt = '0;
      open_len_nxt   = '0;
      byte_pos_nxt   = '0;
    end else begin
      byte_pos_nxt = sat_inc(byte_pos);
    end
  end

  // pack the closed token first, then the byte's own token
  always_comb begin
    res_cnt      = {1'b0, close_vld} + {1'b0, own_vld};
    res_kind[0]  = close_vld ? close_kind : own_kind;
    res_start[0] = close_vld ? open_start : own_start;
    res_len[0]   = close_vld ? close_len : ONE;
    res_kind[1]  = own_kind;
    res_start[1] = own_start;
    res_len[1]   = ONE;
  end

endmodule
